// ===== hw/rtl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared widths, reset values, register indexes and prescaler decode for the
// clock-tree baud divisor.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int FREQ_W    = 26;
    localparam int CLK_W     = 32;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 26;
    localparam int M_W       = 6;
    localparam int N_W       = 9;
    localparam int PCODE_W   = 2;
    localparam int SW_W      = 2;
    localparam int PRE_W     = 10;
    localparam int SHIFT_W   = 4;

    // 2*pclk + baud needs 34 bits, hence 34 quotient bits
    localparam int DIVD_W    = CLK_W + 2;
    localparam int DIVS_W    = FREQ_W + 1;

    // x/3 for x < 2^25: (x * ceil(2^26/3)) >> 26
    localparam int DIV3_SH   = 26;
    localparam logic [FREQ_W-2:0] DIV3_RECIP = 25'd22369622;

    localparam logic [FREQ_W-1:0]  HSE_RST = 26'd8000000;
    localparam logic [FREQ_W-1:0]  HSI_RST = 26'd16000000;
    localparam logic [M_W-1:0]     M_RST   = 6'd16;
    localparam logic [N_W-1:0]     N_RST   = 9'd192;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HSE_HZ   = 3'd0,
        REG_HSI_HZ   = 3'd1,
        REG_PLL_SRC  = 3'd2,
        REG_PLL_M    = 3'd3,
        REG_PLL_N    = 3'd4,
        REG_PLL_P    = 3'd5,
        REG_SYSCLK   = 3'd6,
        REG_PRESCALE = 3'd7
    } cfg_idx_t;

    typedef enum logic [SW_W-1:0] {
        SYS_HSI   = 2'd0,
        SYS_HSE   = 2'd1,
        SYS_PLL   = 2'd2,
        SYS_HSI_B = 2'd3
    } sysclk_t;

    typedef enum logic [PCODE_W-1:0] {
        PDIV_2 = 2'd0,
        PDIV_4 = 2'd1,
        PDIV_6 = 2'd2,
        PDIV_8 = 2'd3
    } pdiv_t;

    // AHB prescaler as a right shift
    function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [3:0] code);
        logic [SHIFT_W-1:0] s;
        case (code)
            4'd8:    s = 4'd1;
            4'd9:    s = 4'd2;
            4'd10:   s = 4'd3;
            4'd11:   s = 4'd4;
            4'd12:   s = 4'd6;
            4'd13:   s = 4'd7;
            4'd14:   s = 4'd8;
            4'd15:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // APB prescaler as a right shift
    function automatic logic [SHIFT_W-1:0] apb_shift(input logic [2:0] code);
        logic [SHIFT_W-1:0] s;
        case (code)
            3'd4:    s = 4'd1;
            3'd5:    s = 4'd2;
            3'd6:    s = 4'd3;
            3'd7:    s = 4'd4;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/clock_tree_baud_divisor_core.sv =====
// ----------------------------------------------------------------------------
// clock_tree_baud_divisor_core
// Derives the peripheral bus clock from the clock-tree settings and returns
// the UART divisor word for each baud request.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------
//   request   start / busy         baud_hz, oversample_by_8, on_apb2
//   result    done (one cycle)     divisor_word, bus_clock_hz,
//                                  divisor_overflow
//   config    cfg_wr_en            cfg_index, cfg_data
//
// One word enters per cycle; busy is held low. Each word passes through
// 26 steps of the PLL input divider, 34 steps of the restoring baud
// divider, and five further register stages. rst_n clears the valid bits
// and loads the register reset values. Results cannot be held off, so the
// pipeline never stalls.
// ----------------------------------------------------------------------------
module clock_tree_baud_divisor_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [cbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbd_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [cbd_pkg::FREQ_W-1:0]     baud_hz,
    input  logic                           oversample_by_8,
    input  logic                           on_apb2,
    output logic                           done,
    output logic [cbd_pkg::WORD_W-1:0]     divisor_word,
    output logic [cbd_pkg::CLK_W-1:0]      bus_clock_hz,
    output logic                           divisor_overflow
);
    import cbd_pkg::*;

    localparam int A_STEPS = FREQ_W;
    localparam int B_STEPS = DIVD_W;
    localparam int LAT     = A_STEPS + B_STEPS + 4;

    // ---------------- configuration registers ----------------
    logic [FREQ_W-1:0]  hse_reg, hsi_reg;
    logic               psrc_reg;
    logic [M_W-1:0]     pm_reg;
    logic [N_W-1:0]     pn_reg;
    logic [PCODE_W-1:0] pp_reg;
    logic [SW_W-1:0]    sw_reg;
    logic [PRE_W-1:0]   pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hse_reg  <= HSE_RST;
            hsi_reg  <= HSI_RST;
            psrc_reg <= 1'b0;
            pm_reg   <= M_RST;
            pn_reg   <= N_RST;
            pp_reg   <= '0;
            sw_reg   <= '0;
            pre_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_HSE_HZ:   hse_reg  <= cfg_data;
                REG_HSI_HZ:   hsi_reg  <= cfg_data;
                REG_PLL_SRC:  psrc_reg <= cfg_data[0];
                REG_PLL_M:    pm_reg   <= cfg_data[M_W-1:0];
                REG_PLL_N:    pn_reg   <= cfg_data[N_W-1:0];
                REG_PLL_P:    pp_reg   <= cfg_data[PCODE_W-1:0];
                REG_SYSCLK:   sw_reg   <= cfg_data[SW_W-1:0];
                REG_PRESCALE: pre_reg  <= cfg_data[PRE_W-1:0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [M_W-1:0] m_eff;
    assign m_eff = (pm_reg == '0) ? M_W'(1) : pm_reg;

    // ---------------- PLL input divider: src / M ----------------
    logic              a_vld_reg  [0:A_STEPS];
    logic [M_W-1:0]    a_rem_reg  [0:A_STEPS];
    logic [FREQ_W-1:0] a_quo_reg  [0:A_STEPS];
    logic [FREQ_W-1:0] a_baud_reg [0:A_STEPS];
    logic              a_by8_reg  [0:A_STEPS];
    logic              a_apb2_reg [0:A_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg[0] <= 1'b0;
        else
            a_vld_reg[0] <= start;
    end

    always_ff @(posedge clk)
    begin
        a_rem_reg[0]  <= '0;
        a_quo_reg[0]  <= psrc_reg ? hse_reg : hsi_reg;
        a_baud_reg[0] <= baud_hz;
        a_by8_reg[0]  <= oversample_by_8;
        a_apb2_reg[0] <= on_apb2;
    end

    for (genvar k = 0; k < A_STEPS; k++)
    begin : g_adiv
        logic [M_W:0]      t;
        logic              qb;
        logic [M_W-1:0]    rem_next;
        logic [FREQ_W-1:0] quo_next;

        always_comb
        begin
            t        = {a_rem_reg[k], a_quo_reg[k][FREQ_W-1]};
            qb       = (t >= {1'b0, m_eff});
            rem_next = qb ? M_W'(t - {1'b0, m_eff}) : t[M_W-1:0];
            quo_next = {a_quo_reg[k][FREQ_W-2:0], qb};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                a_vld_reg[k+1] <= 1'b0;
            else
                a_vld_reg[k+1] <= a_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            a_rem_reg[k+1]  <= rem_next;
            a_quo_reg[k+1]  <= quo_next;
            a_baud_reg[k+1] <= a_baud_reg[k];
            a_by8_reg[k+1]  <= a_by8_reg[k];
            a_apb2_reg[k+1] <= a_apb2_reg[k];
        end
    end

    // ---------------- PLL output divider P ----------------
    logic [FREQ_W-1:0]      v_in;
    logic [FREQ_W-2:0]      half;
    logic [2*FREQ_W-3:0]    prod3;
    logic [FREQ_W-1:0]      p_val_next;
    logic                   p_vld_reg;
    logic [FREQ_W-1:0]      p_val_reg, p_baud_reg;
    logic                   p_by8_reg, p_apb2_reg;

    always_comb
    begin
        v_in  = a_quo_reg[A_STEPS];
        half  = v_in[FREQ_W-1:1];
        prod3 = half * DIV3_RECIP;
        case (pdiv_t'(pp_reg))
            PDIV_2:  p_val_next = v_in >> 1;
            PDIV_4:  p_val_next = v_in >> 2;
            PDIV_6:  p_val_next = FREQ_W'(prod3 >> DIV3_SH);
            PDIV_8:  p_val_next = v_in >> 3;
            default: p_val_next = v_in >> 1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else
            p_vld_reg <= a_vld_reg[A_STEPS];
    end

    always_ff @(posedge clk)
    begin
        p_val_reg  <= p_val_next;
        p_baud_reg <= a_baud_reg[A_STEPS];
        p_by8_reg  <= a_by8_reg[A_STEPS];
        p_apb2_reg <= a_apb2_reg[A_STEPS];
    end

    // ---------------- PLL multiplier N ----------------
    logic                   n_vld_reg;
    logic [CLK_W-1:0]       n_pll_reg;
    logic [FREQ_W-1:0]      n_baud_reg;
    logic                   n_by8_reg, n_apb2_reg;
    logic [FREQ_W+N_W-1:0]  nprod;

    assign nprod = p_val_reg * pn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else
            n_vld_reg <= p_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        n_pll_reg  <= nprod[CLK_W-1:0];
        n_baud_reg <= p_baud_reg;
        n_by8_reg  <= p_by8_reg;
        n_apb2_reg <= p_apb2_reg;
    end

    // ---------------- clock select, prescalers, divider setup ----------------
    logic [CLK_W-1:0]   sys_clk, pclk;
    logic [SHIFT_W-1:0] sh;

    always_comb
    begin
        case (sysclk_t'(sw_reg))
            SYS_HSE: sys_clk = CLK_W'(hse_reg);
            SYS_PLL: sys_clk = n_pll_reg;
            default: sys_clk = CLK_W'(hsi_reg);
        endcase
        sh   = ahb_shift(pre_reg[3:0])
             + apb_shift(n_apb2_reg ? pre_reg[9:7] : pre_reg[6:4]);
        pclk = sys_clk >> sh;
    end

    logic              b_vld_reg  [0:B_STEPS];
    logic [FREQ_W:0]   b_rem_reg  [0:B_STEPS];
    logic [DIVD_W-1:0] b_quo_reg  [0:B_STEPS];
    logic [FREQ_W-1:0] b_baud_reg [0:B_STEPS];
    logic [CLK_W-1:0]  b_pclk_reg [0:B_STEPS];
    logic              b_by8_reg  [0:B_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg[0] <= 1'b0;
        else
            b_vld_reg[0] <= n_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_rem_reg[0]  <= '0;
        b_quo_reg[0]  <= DIVD_W'({pclk, 1'b0}) + DIVD_W'(n_baud_reg);
        b_baud_reg[0] <= n_baud_reg;
        b_pclk_reg[0] <= pclk;
        b_by8_reg[0]  <= n_by8_reg;
    end

    // ---------------- baud divider: (2*pclk + baud) / (2*baud) ----------------
    for (genvar k = 0; k < B_STEPS; k++)
    begin : g_bdiv
        logic [DIVS_W:0]   t;
        logic [DIVS_W:0]   d;
        logic              qb;
        logic [FREQ_W:0]   rem_next;
        logic [DIVD_W-1:0] quo_next;

        always_comb
        begin
            t        = {b_rem_reg[k], b_quo_reg[k][DIVD_W-1]};
            d        = {1'b0, b_baud_reg[k], 1'b0};
            qb       = (t >= d);
            rem_next = qb ? DIVS_W'(t - d) : t[DIVS_W-1:0];
            quo_next = {b_quo_reg[k][DIVD_W-2:0], qb};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                b_vld_reg[k+1] <= 1'b0;
            else
                b_vld_reg[k+1] <= b_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            b_rem_reg[k+1]  <= rem_next;
            b_quo_reg[k+1]  <= quo_next;
            b_baud_reg[k+1] <= b_baud_reg[k];
            b_pclk_reg[k+1] <= b_pclk_reg[k];
            b_by8_reg[k+1]  <= b_by8_reg[k];
        end
    end

    // ---------------- word packing and output register ----------------
    logic [DIVD_W-1:0] r;
    logic [WORD_W-1:0] word_next;
    logic              ovf_next;

    always_comb
    begin
        r = b_quo_reg[B_STEPS];
        if (b_baud_reg[B_STEPS] == '0)
        begin
            word_next = '1;
            ovf_next  = 1'b1;
        end
        else if (b_by8_reg[B_STEPS])
        begin
            word_next = {r[14:3], r[2:0], 1'b0};
            ovf_next  = |r[DIVD_W-1:15];
        end
        else
        begin
            word_next = r[WORD_W-1:0];
            ovf_next  = |r[DIVD_W-1:16];
        end
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= b_vld_reg[B_STEPS];
    end

    always_ff @(posedge clk)
    begin
        divisor_word     <= word_next;
        bus_clock_hz     <= b_pclk_reg[B_STEPS];
        divisor_overflow <= ovf_next;
    end

    assign done = done_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg[0] |-> ##LAT done)
        else $error("word did not reach the output in time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg[0] |-> $past(a_vld_reg[0], A_STEPS + 3))
        else $error("baud divider started without a request");

    a_arem: assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg[A_STEPS] |-> (a_rem_reg[A_STEPS] < m_eff))
        else $error("PLL divider remainder out of range");

    a_brem: assert property (@(posedge clk) disable iff (!rst_n)
        (b_vld_reg[B_STEPS] && b_baud_reg[B_STEPS] != '0)
        |-> (b_rem_reg[B_STEPS] < {b_baud_reg[B_STEPS], 1'b0}))
        else $error("baud divider remainder out of range");

endmodule

// ===== tb/tb_clock_tree_baud_divisor_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clock_tree_baud_divisor_core
// Self-checking bench: steps the clock tree through several settings, sends
// directed and random baud requests and checks every returned word against
// a behavioural divisor calculator, or against the word given in a typed row.
// ----------------------------------------------------------------------------
module tb_clock_tree_baud_divisor_core;
    import cbd_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CLK_W-1:0]  pclk;
        logic              ovf;
    } baud_result_t;

    typedef struct packed {
        logic [FREQ_W-1:0] baud;
        logic              by8;
        logic              apb2;
        logic              typed;
        logic [WORD_W-1:0] word;
        logic              ovf;
    } request_row_t;

    localparam int WATCHDOG_LIMIT = 3000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 start;
    logic                 busy;
    logic [FREQ_W-1:0]    baud_hz;
    logic                 oversample_by_8;
    logic                 on_apb2;
    logic                 done;
    logic [WORD_W-1:0]    divisor_word;
    logic [CLK_W-1:0]     bus_clock_hz;
    logic                 divisor_overflow;

    // mirror of the clock-tree registers
    logic [FREQ_W-1:0] hse_q, hsi_q;
    logic              src_q;
    logic [M_W-1:0]    m_q;
    logic [N_W-1:0]    n_q;
    logic [PCODE_W-1:0] p_q;
    logic [SW_W-1:0]   sw_q;
    logic [PRE_W-1:0]  pre_q;

    baud_result_t pending_words[$];
    int  mismatches;
    int  quiet_cycles;
    bit  idling_on;

    clock_tree_baud_divisor_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .baud_hz(baud_hz), .oversample_by_8(oversample_by_8), .on_apb2(on_apb2),
        .done(done), .divisor_word(divisor_word), .bus_clock_hz(bus_clock_hz),
        .divisor_overflow(divisor_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [CLK_W-1:0] bus_clock(input logic apb2);
        logic [CLK_W-1:0] src, sys, hclk;
        int unsigned ahb_sh[8] = '{1, 2, 3, 4, 6, 7, 8, 9};
        logic [3:0] ahb_code;
        logic [2:0] apb_code;
        src = src_q ? CLK_W'(hse_q) : CLK_W'(hsi_q);
        case (sw_q)
            SYS_HSE: sys = CLK_W'(hse_q);
            SYS_PLL: sys = ((src / ((m_q == 0) ? 1 : m_q)) / (2 * (p_q + 1))) * n_q;
            default: sys = CLK_W'(hsi_q);
        endcase
        ahb_code = pre_q[3:0];
        hclk = (ahb_code >= 8) ? (sys >> ahb_sh[ahb_code - 8]) : sys;
        apb_code = apb2 ? pre_q[9:7] : pre_q[6:4];
        return (apb_code >= 4) ? (hclk >> (apb_code - 3)) : hclk;
    endfunction

    function automatic baud_result_t compute_divisor(input logic [FREQ_W-1:0] baud,
                                                     input logic by8, input logic apb2);
        baud_result_t res;
        longint unsigned r, mant, w;
        res.pclk = bus_clock(apb2);
        if (baud == 0)
        begin
            res.word = 16'hFFFF;
            res.ovf  = 1'b1;
        end
        else
        begin
            r = (2 * longint'(res.pclk) + baud) / (2 * longint'(baud));
            if (by8)
            begin
                mant = r >> 3;
                w = (mant << 4) | ((r & 7) << 1);
            end
            else
            begin
                mant = r >> 4;
                w = r;
            end
            res.word = w[WORD_W-1:0];
            res.ovf  = (mant > 4095);
        end
        return res;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            REG_HSE_HZ:   hse_q = d;
            REG_HSI_HZ:   hsi_q = d;
            REG_PLL_SRC:  src_q = d[0];
            REG_PLL_M:    m_q   = d[M_W-1:0];
            REG_PLL_N:    n_q   = d[N_W-1:0];
            REG_PLL_P:    p_q   = d[PCODE_W-1:0];
            REG_SYSCLK:   sw_q  = d[SW_W-1:0];
            default:      pre_q = d[PRE_W-1:0];
        endcase
    endtask

    task automatic load_tree(input logic [25:0] hse, input logic [25:0] hsi,
                             input logic src, input logic [5:0] m, input logic [8:0] n,
                             input logic [1:0] p, input logic [1:0] sw,
                             input logic [9:0] pre);
        write_reg(REG_HSE_HZ, hse);
        write_reg(REG_HSI_HZ, hsi);
        write_reg(REG_PLL_SRC, CFG_DAT_W'(src));
        write_reg(REG_PLL_M, CFG_DAT_W'(m));
        write_reg(REG_PLL_N, CFG_DAT_W'(n));
        write_reg(REG_PLL_P, CFG_DAT_W'(p));
        write_reg(REG_SYSCLK, CFG_DAT_W'(sw));
        write_reg(REG_PRESCALE, CFG_DAT_W'(pre));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_request(input request_row_t row);
        baud_result_t exp_word;
        while (idling_on && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start           <= 1'b1;
        baud_hz         <= row.baud;
        oversample_by_8 <= row.by8;
        on_apb2         <= row.apb2;
        @(posedge clk);
        while (busy) @(posedge clk);
        exp_word = compute_divisor(row.baud, row.by8, row.apb2);
        if (row.typed)
        begin
            exp_word.word = row.word;
            exp_word.ovf  = row.ovf;
        end
        pending_words.push_back(exp_word);
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
        @(negedge clk);
    endtask

    // result check
    always @(posedge clk)
    begin
        baud_result_t e;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h %h %b", divisor_word, bus_clock_hz,
                             divisor_overflow);
            end
            else
            begin
                e = pending_words.pop_front();
                if (divisor_word !== e.word || bus_clock_hz !== e.pclk ||
                    divisor_overflow !== e.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %b got %h %h %b", e.word, e.pclk,
                                 e.ovf, divisor_word, bus_clock_hz, divisor_overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_wr_en || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_clock_tree_baud_divisor_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        request_row_t directed[] = '{
            '{26'd0,        1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b1},
            '{26'd0,        1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1},
            '{26'h3FFFFFF,  1'b0, 1'b0, 1'b1, 16'h0000, 1'b0},
            '{26'h3FFFFFF,  1'b1, 1'b1, 1'b1, 16'h0000, 1'b0},
            '{26'd1,        1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'd1,        1'b1, 1'b1, 1'b0, 16'h0, 1'b0},
            '{26'd115200,   1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'd115200,   1'b1, 1'b1, 1'b0, 16'h0, 1'b0},
            '{26'd9600,     1'b0, 1'b1, 1'b0, 16'h0, 1'b0},
            '{26'd9600,     1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'd244,      1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'd245,      1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'd488,      1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'd16000000, 1'b0, 1'b1, 1'b0, 16'h0, 1'b0},
            '{26'd32000000, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
            '{26'h2AAAAAA,  1'b0, 1'b1, 1'b0, 16'h0, 1'b0},
            '{26'h1555555,  1'b1, 1'b0, 1'b0, 16'h0, 1'b0}
        };
        request_row_t row;
        logic [CLK_W-1:0] pclk;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        baud_hz = '0;
        oversample_by_8 = 1'b0;
        on_apb2 = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        idling_on = 1'b1;
        hse_q = HSE_RST; hsi_q = HSI_RST; src_q = 1'b0; m_q = M_RST; n_q = N_RST;
        p_q = PDIV_2; sw_q = SYS_HSI; pre_q = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i]) send_request(directed[i]);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: ;
                1: load_tree(26'd50000000, 26'd1, 1'b1, 6'd0, 9'd511, PDIV_2, SYS_PLL,
                             10'h3FF);
                2: load_tree(26'h3FFFFFF, 26'h3FFFFFF, 1'b0, 6'd63, 9'd0, PDIV_8,
                             SYS_HSE, 10'h000);
                3: load_tree(26'd1, 26'd50000000, 1'b1, 6'd2, 9'd432, PDIV_4, SYS_PLL,
                             10'h2A8);
                default: load_tree(FREQ_W'($urandom()),
                                   FREQ_W'($urandom_range(1, 50000000)),
                                   1'($urandom()), M_W'($urandom()), N_W'($urandom()),
                                   PCODE_W'($urandom()), SW_W'($urandom()),
                                   PRE_W'($urandom()));
            endcase
            idling_on = (ph != 4);
            for (int k = 0; k < 250; k++)
            begin
                row = '0;
                row.by8  = 1'($urandom());
                row.apb2 = 1'($urandom());
                pclk = bus_clock(row.apb2);
                case ($urandom_range(0, 3))
                    0: row.baud = FREQ_W'($urandom());
                    1: row.baud = FREQ_W'($urandom_range(1, 200000));
                    2: row.baud = FREQ_W'((pclk / $urandom_range(16, 70000))
                                          + $urandom_range(0, 3));
                    default: row.baud = FREQ_W'($urandom_range(0, 16));
                endcase
                send_request(row);
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb_clock_tree_baud_divisor_core: done, clean");
        else
            $display("tb_clock_tree_baud_divisor_core: done, errors");
        $finish;
    end

endmodule
